FILE: rtl/sorted_aabb_overlap_table_macros.svh
// Assertion shorthands used by the table RTL.
`ifndef SORTED_AABB_OVERLAP_TABLE_MACROS_SVH
`define SORTED_AABB_OVERLAP_TABLE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SABT_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define SABT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SABT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sabt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sabt_pkg;

    localparam int COORD_W = 16;
    localparam int BODY_W  = 16;
    localparam int KIND_W  = 2;

    localparam logic [KIND_W-1:0] KIND_INSERTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HIT      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE     = 2'd3;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // One stored box.
    typedef struct packed {
        logic        [BODY_W-1:0]  body;
        logic signed [COORD_W-1:0] x_min;
        logic signed [COORD_W-1:0] x_max;
        logic signed [COORD_W-1:0] y_min;
        logic signed [COORD_W-1:0] y_max;
        logic signed [COORD_W-1:0] z_min;
        logic signed [COORD_W-1:0] z_max;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } cell_op_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/sabt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One table slot. Insert: shift up from the left neighbor or take the new box.
// Rotate: take the right neighbor's entry (the chain wraps around).
module sabt_cell
    import sabt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 6
)
(
    input  wire logic          clk,
    input  wire cell_ctrl_t    ctrl,
    input  wire logic [CW-1:0] count,
    input  wire entry_t        prev_entry,
    input  wire logic          prev_gt,
    input  wire entry_t        next_entry,
    output entry_t             entry,
    output logic               gt
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;
    logic   at_end;

    assign occupied = count > CW'(IDX);
    assign at_end   = count == CW'(IDX);
    // Stored x minimum strictly above the new one: this slot moves up.
    assign gt = occupied && ($signed(entry_reg.x_min) > $signed(ctrl.new_entry.x_min));

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (prev_gt)
                begin
                    entry_next = prev_entry;
                end
                else if (gt || at_end)
                begin
                    entry_next = ctrl.new_entry;
                end
            end
            CELL_ROTATE:
            begin
                entry_next = next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

FILE: rtl/sorted_aabb_overlap_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel     Handshake                      Payload
// request     start in, busy out             req_type, body_id, x/y/z min/max
// result      result_strobe out (no stall)   kind, hit_body, last
//
// Insert: the box is captured, then ST_INSERT shifts the chain and sets the result.
// Query: the table rotates one slot per cycle through cell 0, where the overlap
// test sits, and is back in place after TABLE_DEPTH steps.
// The closing result follows the last rotate step. A new transaction may start
// while the previous result is still on the output register.
// Reset (rst_n, async, active low) empties the table; slot contents are not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
module sorted_aabb_overlap_table
    import sabt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       req_type,
    input  wire logic        [BODY_W-1:0]   body_id,
    input  wire logic signed [COORD_W-1:0]  x_min,
    input  wire logic signed [COORD_W-1:0]  x_max,
    input  wire logic signed [COORD_W-1:0]  y_min,
    input  wire logic signed [COORD_W-1:0]  y_max,
    input  wire logic signed [COORD_W-1:0]  z_min,
    input  wire logic signed [COORD_W-1:0]  z_max,
    output logic                            result_strobe,
    output logic             [KIND_W-1:0]   kind,
    output logic             [BODY_W-1:0]   hit_body,
    output logic                            last
);

`include "sorted_aabb_overlap_table_macros.svh"

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = $clog2(TABLE_DEPTH);
    localparam logic [SW-1:0] LAST_STEP  = SW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    // Sequencer state
    state_t              state_reg, state_next;
    entry_t              q_reg, q_next;          // captured transaction box
    logic                req_reg, req_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [SW-1:0]       step_reg, step_next;    // rotate step during a query
    logic                active_reg, active_next; // sweep still inside x range

    // Result register
    logic                strobe_reg, strobe_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [BODY_W-1:0]   hit_body_reg, hit_body_next;
    logic                last_reg, last_next;

    cell_ctrl_t          ctrl;
    entry_t              ent [TABLE_DEPTH];
    logic                gt  [TABLE_DEPTH];

    logic                accept;
    logic                in_range;
    logic                overlap;
    entry_t              head;

    assign busy   = state_reg != ST_IDLE;
    assign accept = start && !busy;
    assign head   = ent[0];

    // Chain of slots; slot i shifts from i-1 on insert and takes i+1 on rotate.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % TABLE_DEPTH;
        entry_t prev_e;
        logic   prev_g;

        if (i == 0)
        begin : g_first
            assign prev_e = '0;
            assign prev_g = 1'b0;
        end
        else
        begin : g_rest
            assign prev_e = ent[i-1];
            assign prev_g = gt[i-1];
        end

        sabt_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .prev_entry (prev_e),
            .prev_gt    (prev_g),
            .next_entry (ent[NXT]),
            .entry      (ent[i]),
            .gt         (gt[i])
        );
    end

    // Sweep test on the slot currently at the head of the chain.
    assign in_range = (CW'(step_reg) < count_reg) &&
                      ($signed(q_reg.x_max) > $signed(head.x_min));
    assign overlap  = ($signed(q_reg.x_min) < $signed(head.x_max)) &&
                      ($signed(q_reg.y_max) > $signed(head.y_min)) &&
                      ($signed(q_reg.y_min) < $signed(head.y_max)) &&
                      ($signed(q_reg.z_max) > $signed(head.z_min)) &&
                      ($signed(q_reg.z_min) < $signed(head.z_max));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_type == REQ_QUERY) ? ST_SCAN : ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        q_next         = q_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        active_next    = active_reg;
        strobe_next    = 1'b0;
        kind_next      = KIND_INSERTED;
        hit_body_next  = '0;
        last_next      = 1'b0;
        ctrl.op        = CELL_HOLD;
        ctrl.new_entry = q_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    q_next.body  = body_id;
                    q_next.x_min = x_min;
                    q_next.x_max = x_max;
                    q_next.y_min = y_min;
                    q_next.y_max = y_max;
                    q_next.z_min = z_min;
                    q_next.z_max = z_max;
                    req_next     = req_type;
                    step_next    = '0;
                    active_next  = 1'b1;
                end
            end
            ST_INSERT:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                if (count_reg == FULL_COUNT)
                begin
                    kind_next = KIND_FULL;
                end
                else
                begin
                    ctrl.op    = CELL_INSERT;
                    count_next = count_reg + CW'(1);
                    kind_next  = KIND_INSERTED;
                end
            end
            ST_SCAN:
            begin
                ctrl.op     = CELL_ROTATE;
                step_next   = step_reg + SW'(1);
                active_next = active_reg && in_range;
                if (active_reg && in_range && overlap)
                begin
                    strobe_next   = 1'b1;
                    kind_next     = KIND_HIT;
                    hit_body_next = head.body;
                end
            end
            ST_DONE:
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_DONE;
                last_next   = 1'b1;
            end
            default:
            begin
                ctrl.op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            step_reg   <= '0;
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            active_reg <= active_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        req_reg      <= req_next;
        kind_reg     <= kind_next;
        hit_body_reg <= hit_body_next;
        last_reg     <= last_next;
    end

    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign hit_body      = hit_body_reg;
    assign last          = last_reg;

    // Checks
    `SABT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= FULL_COUNT,
        "entry count above table depth")
    `SABT_ASSERT_NEXT(a_insert_count, clk, rst_n,
        (state_reg == ST_INSERT) && (count_reg != FULL_COUNT),
        count_reg == $past(count_reg) + CW'(1), "insert did not grow the table")
    `SABT_ASSERT_IMPLY(a_hit_from_scan, clk, rst_n,
        result_strobe && (kind == KIND_HIT),
        !last && ($past(state_reg) == ST_SCAN) && ($past(req_reg) == REQ_QUERY),
        "overlap hit outside a query sweep")
    `SABT_ASSERT_IMPLY(a_last_kinds, clk, rst_n, result_strobe && last,
        (kind == KIND_INSERTED) || (kind == KIND_FULL) || (kind == KIND_DONE),
        "closing result of wrong kind")
    `SABT_ASSERT_NEXT(a_scan_holds_count, clk, rst_n, state_reg == ST_SCAN,
        count_reg == $past(count_reg), "table size changed during a query")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the sorted box table with the x-axis sweep query.
//
// Stimulus is sent one transaction at a time over start/busy. The bench
// predicts the outcome of each transaction at the edge where it is
// accepted. It keeps its own sorted copy of the stored boxes for this.
// The predicted results wait in a queue. A monitor compares every strobed
// result, field by field, with the oldest entry in that queue. The receiver
// side has no back-pressure, so only the sender idles.
//
// The table cannot be emptied without a reset, and reset is applied once.
// So the run goes from an empty table through a partly filled one to a
// full one. Queries get deeper as the run goes on.
module testbench;
    import sabt_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [BODY_W-1:0] hit_body;
        logic              last;
    } outcome_t;

    // ---------------------------------------------------------------- DUT I/O
    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      req_type;
    logic        [BODY_W-1:0]  body_id;
    logic signed [COORD_W-1:0] x_min;
    logic signed [COORD_W-1:0] x_max;
    logic signed [COORD_W-1:0] y_min;
    logic signed [COORD_W-1:0] y_max;
    logic signed [COORD_W-1:0] z_min;
    logic signed [COORD_W-1:0] z_max;
    logic                      result_strobe;
    logic        [KIND_W-1:0]  kind;
    logic        [BODY_W-1:0]  hit_body;
    logic                      last;

    sorted_aabb_overlap_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .body_id      (body_id),
        .x_min        (x_min),
        .x_max        (x_max),
        .y_min        (y_min),
        .y_max        (y_max),
        .z_min        (z_min),
        .z_max        (z_max),
        .result_strobe(result_strobe),
        .kind         (kind),
        .hit_body     (hit_body),
        .last         (last)
    );

    // ------------------------------------------------------- predictor state
    // The bench's own copy of the sorted table. Only the first stored_count
    // slots mean anything.
    entry_t   stored_boxes [TABLE_DEPTH];
    int       stored_count;
    outcome_t pending_results [$];
    int       mismatch_count;
    int       cycle_count = 0;

    // ---------------------------------------------------------------- clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Safety net: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------- predictor
    // Append one expected result at the tail of the queue.
    task automatic queue_outcome(input outcome_t res);
        begin
            pending_results.insert(pending_results.size(), res);
        end
    endtask

    // Apply one accepted transaction to the shadow table and queue the
    // results it must produce.
    task automatic predict_transaction(input logic req, input entry_t box);
        int       slot;
        outcome_t res;
        begin
            res.hit_body = '0;
            res.last     = 1'b1;
            if (req == REQ_INSERT)
            begin
                if (stored_count >= TABLE_DEPTH)
                begin
                    res.kind = KIND_FULL;
                end
                else
                begin
                    // New box goes after every entry with x_min <= its own,
                    // so equal keys keep arrival order.
                    slot = stored_count;
                    while (slot > 0 && stored_boxes[slot-1].x_min > box.x_min)
                    begin
                        stored_boxes[slot] = stored_boxes[slot-1];
                        slot--;
                    end
                    stored_boxes[slot] = box;
                    stored_count++;
                    res.kind = KIND_INSERTED;
                end
                queue_outcome(res);
            end
            else
            begin
                // Sweep from slot 0 while the entry still starts strictly
                // below the query's x_max; all tests are strict.
                for (slot = 0; slot < stored_count; slot++)
                begin
                    if (!(box.x_max > stored_boxes[slot].x_min))
                        break;
                    if (box.x_min < stored_boxes[slot].x_max &&
                        box.y_max > stored_boxes[slot].y_min &&
                        box.y_min < stored_boxes[slot].y_max &&
                        box.z_max > stored_boxes[slot].z_min &&
                        box.z_min < stored_boxes[slot].z_max)
                    begin
                        res.kind     = KIND_HIT;
                        res.hit_body = stored_boxes[slot].body;
                        res.last     = 1'b0;
                        queue_outcome(res);
                    end
                end
                res.kind     = KIND_DONE;
                res.hit_body = '0;
                res.last     = 1'b1;
                queue_outcome(res);
            end
        end
    endtask

    // ---------------------------------------------------------------- checker
    task automatic report_mismatch(input string what, input outcome_t want,
                                   input outcome_t got);
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display(
                    "%0t %s: expected kind=%0d body=%h last=%0d, got kind=%0d body=%h last=%0d",
                    $realtime, what, want.kind, want.hit_body, want.last,
                    got.kind, got.hit_body, got.last);
        end
    endtask

    // Results cannot be held off, so every strobe is consumed on its edge.
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && result_strobe)
        begin
            got.kind     = kind;
            got.hit_body = hit_body;
            got.last     = last;
            if (pending_results.size() == 0)
            begin
                want = '{kind: 'x, hit_body: 'x, last: 'x};
                report_mismatch("unexpected result", want, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.hit_body !== want.hit_body ||
                    got.last !== want.last)
                    report_mismatch("result", want, got);
            end
        end
    end

    // ------------------------------------------------------------ stimulus
    // Drive one transaction. With idle_pct percent odds per cycle the sender
    // holds start low first. start is left high after the accept; the next
    // call (or the drain) decides its next value at the following falling edge.
    task automatic send_transaction(input logic req, input entry_t box,
                                    input int idle_pct);
        begin
            @(negedge clk);
            while ($urandom_range(99) < idle_pct)
            begin
                start = 1'b0;
                @(negedge clk);
            end
            req_type = req;
            body_id  = box.body;
            x_min    = box.x_min;
            x_max    = box.x_max;
            y_min    = box.y_min;
            y_max    = box.y_max;
            z_min    = box.z_min;
            z_max    = box.z_max;
            start    = 1'b1;
            do
                @(posedge clk);
            while (busy);
            predict_transaction(req, box);
        end
    endtask

    function automatic entry_t box_of(input logic [BODY_W-1:0] body,
                                      input int xa, input int xb,
                                      input int ya, input int yb,
                                      input int za, input int zb);
        entry_t box;
        box.body  = body;
        box.x_min = COORD_W'(xa);
        box.x_max = COORD_W'(xb);
        box.y_min = COORD_W'(ya);
        box.y_max = COORD_W'(yb);
        box.z_min = COORD_W'(za);
        box.z_max = COORD_W'(zb);
        return box;
    endfunction

    // Mostly a small cluster around zero so boxes overlap. Some values come
    // from the full range and the extremes so that every bit toggles.
    function automatic logic [COORD_W-1:0] pick_coord();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return COORD_W'($urandom);
        else if (roll < 20)
            case ($urandom_range(3))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'h0000;
                default: return 16'hffff;
            endcase
        else
            return COORD_W'(int'($urandom_range(511)) - 256);
    endfunction

    function automatic entry_t random_box(input logic as_query);
        entry_t box;
        int     pick;
        box.body  = BODY_W'($urandom);
        box.x_min = pick_coord();
        box.y_min = pick_coord();
        box.z_min = pick_coord();
        if ($urandom_range(9) == 0)
        begin
            // unrelated bounds: often inverted
            box.x_max = pick_coord();
            box.y_max = pick_coord();
            box.z_max = pick_coord();
        end
        else
        begin
            box.x_max = box.x_min + COORD_W'($urandom_range(200, 1));
            box.y_max = box.y_min + COORD_W'($urandom_range(200, 1));
            box.z_max = box.z_min + COORD_W'($urandom_range(200, 1));
        end
        // Queries sometimes land one bound exactly on a stored bound, where
        // the strict compares decide the outcome.
        if (as_query && stored_count > 0 && $urandom_range(4) == 0)
        begin
            pick = $urandom_range(stored_count - 1);
            case ($urandom_range(5))
                0: box.x_max = stored_boxes[pick].x_min;
                1: box.x_min = stored_boxes[pick].x_max;
                2: box.y_max = stored_boxes[pick].y_min;
                3: box.y_min = stored_boxes[pick].y_max;
                4: box.z_max = stored_boxes[pick].z_min;
                default: box.z_min = stored_boxes[pick].z_max;
            endcase
        end
        // Inserts sometimes reuse a stored x_min to exercise equal sort keys.
        if (!as_query && stored_count > 0 && $urandom_range(5) == 0)
            box.x_min = stored_boxes[$urandom_range(stored_count - 1)].x_min;
        return box;
    endfunction

    // ------------------------------------------------------------ test tasks
    task automatic test_empty_query();
        begin
            // Nothing stored yet: only the closing result.
            send_transaction(REQ_QUERY, box_of(16'h5555, -32768, 32767,
                             -32768, 32767, -32768, 32767), 0);
        end
    endtask

    task automatic test_directed();
        begin
            // Field extremes on insert; the second box is fully inverted.
            send_transaction(REQ_INSERT, box_of(16'h0000, -32768, 32767,
                             -32768, 32767, -32768, 32767), 0);
            send_transaction(REQ_INSERT, box_of(16'hffff, 32767, -32768,
                             32767, -32768, 32767, -32768), 0);
            // Plain boxes; the second has an equal x_min and must land after
            // the first. The third sorts in front of both.
            send_transaction(REQ_INSERT, box_of(16'h1234, 10, 20, 10, 20, 10, 20), 0);
            send_transaction(REQ_INSERT, box_of(16'h1235, 10, 30, 10, 30, 10, 30), 0);
            send_transaction(REQ_INSERT, box_of(16'h0042, 5, 12, 5, 12, 5, 12), 0);
            send_transaction(REQ_INSERT, box_of(16'haaaa, -100, -50, 0, 40, 0, 40), 0);

            // Hits in table order.
            send_transaction(REQ_QUERY, box_of(16'h0001, 0, 40, 0, 40, 0, 40), 0);
            // x_max equal to a stored x_min stops the sweep there.
            send_transaction(REQ_QUERY, box_of(16'h0002, 0, 10, 0, 40, 0, 40), 0);
            // Touching faces on each axis do not count as overlap.
            send_transaction(REQ_QUERY, box_of(16'h0003, 20, 40, 11, 19, 11, 19), 0);
            send_transaction(REQ_QUERY, box_of(16'h0004, 11, 19, 20, 40, 11, 19), 0);
            send_transaction(REQ_QUERY, box_of(16'h0005, 11, 19, 11, 19, 20, 40), 0);
            send_transaction(REQ_QUERY, box_of(16'h0006, 11, 19, 11, 19, -40, 5), 0);
            // Inverted query box.
            send_transaction(REQ_QUERY, box_of(16'h0007, 30, 0, 30, 0, 30, 0), 0);
            // Whole coordinate space.
            send_transaction(REQ_QUERY, box_of(16'h0008, -32768, 32767,
                             -32768, 32767, -32768, 32767), 0);
            // x_max at the bottom of the range: the sweep ends at once.
            send_transaction(REQ_QUERY, box_of(16'h0009, -32768, -32768,
                             -32768, 32767, -32768, 32767), 0);
            // Top of the range on every query bound.
            send_transaction(REQ_QUERY, box_of(16'hffff, 32767, 32767,
                             32767, 32767, 32767, 32767), 0);
        end
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int insert_pct);
        logic is_query;
        begin
            repeat (count)
            begin
                is_query = ($urandom_range(99) >= insert_pct);
                send_transaction(is_query ? REQ_QUERY : REQ_INSERT,
                                 random_box(is_query), idle_pct);
            end
        end
    endtask

    task automatic test_full_table();
        begin
            // Fill whatever room is left, then insert into a full table.
            while (stored_count < TABLE_DEPTH)
                send_transaction(REQ_INSERT, random_box(1'b0), 0);
            repeat (3)
                send_transaction(REQ_INSERT, random_box(1'b0), 10);
            // Deepest query: every entry can hit.
            send_transaction(REQ_QUERY, box_of(16'h7777, -32768, 32767,
                             -32768, 32767, -32768, 32767), 0);
            repeat (4)
                send_transaction(REQ_QUERY, random_box(1'b1), 20);
        end
    endtask

    // ---------------------------------------------------------------- main
    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        req_type       = REQ_INSERT;
        body_id        = '0;
        x_min          = '0;
        x_max          = '0;
        y_min          = '0;
        y_max          = '0;
        z_min          = '0;
        z_max          = '0;
        stored_count   = 0;
        mismatch_count = 0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_empty_query();
        test_directed();
        // First the sender idles often, then more often, then not at all.
        test_random_traffic(45, 36, 25);
        test_random_traffic(45, 53, 25);
        test_random_traffic(45, 0, 20);
        test_full_table();

        @(negedge clk);
        start = 1'b0;

        // Drain, then run on for longer than a full scan so that any stray result
        // still shows.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        mismatch_count += pending_results.size();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
